// ===== sv/mmvp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmvp_pkg
// Shared types and constants for the matrix-matrix-vector product block.
// ----------------------------------------------------------------------------
package mmvp_pkg;

  localparam int VALUE_W   = 32;
  localparam int IDX_W     = 3;
  localparam int OUT_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_LOAD_LEFT   = 2'd0,
    OP_LOAD_RIGHT  = 2'd1,
    OP_LOAD_VECTOR = 2'd2,
    OP_START       = 2'd3
  } op_t;

endpackage

// ===== sv/mmvp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmvp_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mmvp_cmd_if import mmvp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  op_t                       op;
  logic [IDX_W-1:0]          row;
  logic [IDX_W-1:0]          col;
  logic signed [VALUE_W-1:0] value;

  modport source(output valid, op, row, col, value, input ready);
  modport sink(input valid, op, row, col, value, output ready);
endinterface

interface mmvp_res_if import mmvp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OUT_IDX_W-1:0]      out_index;
  logic signed [VALUE_W-1:0] out_value;
  logic                      last;

  modport source(output valid, out_index, out_value, last, input ready);
  modport sink(input valid, out_index, out_value, last, output ready);
endinterface

// ===== sv/matrix_matrix_vector_product_top.sv =====
`timescale 1ns / 1ps
// Throughput: load requests are taken one per cycle while idle.
// Start: each of the ROWS*DIM product entries runs DIM multiply-accumulates through the one
//   shared multiplier, a pipeline drain, one vector multiply and one row add; each row then
//   waits in the emit state until its result is taken. No request is taken during a run.
// Reset: clears the sequencer state, pipeline flags and output valid only; the stores have no clearing pass
//   and hold unknown data until loaded.
// ----------------------------------------------------------------------------
// matrix_matrix_vector_product_top
// Computes ((L * R) * V) row by row with one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module matrix_matrix_vector_product_top import mmvp_pkg::*; #(
  parameter int DIM  = 8,
  parameter int ROWS = 4
) (
  input  logic      clk,
  input  logic      rst,
  mmvp_cmd_if.sink  cmd,
  mmvp_res_if.source res
);

  localparam int DW  = $clog2(DIM);
  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LAW = $clog2(ROWS * DIM);
  localparam int RAW = $clog2(DIM * DIM);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_VMUL,
    ST_VACC,
    ST_EMIT
  } state_t;

  state_t state;

  // Loop counters: i = result row, j = product column, k = inner index.
  logic [RW-1:0] i;
  logic [DW-1:0] j;
  logic [DW-1:0] k;

  // Pipeline flags: read data returning, product register loaded.
  logic rd_valid;
  logic prod_valid;

  logic [VALUE_W-1:0] prod;
  logic [VALUE_W-1:0] prod_next;
  // One product-matrix entry P[i][j]; it is folded into the row sum as soon
  // as it is complete, so the product matrix never needs to be stored whole.
  logic [VALUE_W-1:0] p_acc;
  logic [VALUE_W-1:0] row_acc;

  logic                 out_valid;
  logic [OUT_IDX_W-1:0] out_index;
  logic [VALUE_W-1:0]   out_value;
  logic                 out_last;

  // Store ports
  logic               left_we, right_we, vec_we;
  logic [LAW-1:0]     left_waddr, left_raddr;
  logic [RAW-1:0]     right_waddr, right_raddr;
  logic [DW-1:0]      vec_waddr;
  logic [VALUE_W-1:0] left_rdata, right_rdata, vec_rdata;
  logic [VALUE_W-1:0] mul_a, mul_b;

  logic cmd_fire;
  logic res_fire;

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign res_fire  = res.valid && res.ready;

  assign res.valid     = out_valid;
  assign res.out_index = out_index;
  assign res.out_value = out_value;
  assign res.last      = out_last;

  // Load decode: drop any load whose index falls outside its store.
  always_comb begin
    left_we  = 1'b0;
    right_we = 1'b0;
    vec_we   = 1'b0;
    if (cmd_fire) begin
      unique case (cmd.op)
        OP_LOAD_LEFT:   left_we  = (int'(cmd.row) < ROWS) && (int'(cmd.col) < DIM);
        OP_LOAD_RIGHT:  right_we = (int'(cmd.row) < DIM) && (int'(cmd.col) < DIM);
        OP_LOAD_VECTOR: vec_we   = (int'(cmd.col) < DIM);
        default: ;
      endcase
    end
  end

  assign left_waddr  = LAW'(int'(cmd.row) * DIM + int'(cmd.col));
  assign right_waddr = RAW'(int'(cmd.row) * DIM + int'(cmd.col));
  assign vec_waddr   = DW'(cmd.col);

  // Walk row i of L and column j of R along k.
  assign left_raddr  = LAW'(int'(i) * DIM + int'(k));
  assign right_raddr = RAW'(int'(k) * DIM + int'(j));

  mmvp_ram #(.WIDTH(VALUE_W), .DEPTH(ROWS * DIM)) u_left (
    .clk   (clk),
    .we    (left_we),
    .waddr (left_waddr),
    .wdata (cmd.value),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  mmvp_ram #(.WIDTH(VALUE_W), .DEPTH(DIM * DIM)) u_right (
    .clk   (clk),
    .we    (right_we),
    .waddr (right_waddr),
    .wdata (cmd.value),
    .raddr (right_raddr),
    .rdata (right_rdata)
  );

  // Vector read address follows j; data is long settled before ST_VMUL.
  mmvp_ram #(.WIDTH(VALUE_W), .DEPTH(DIM)) u_vector (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (cmd.value),
    .raddr (j),
    .rdata (vec_rdata)
  );

  // Shared multiplier: L*R terms during the inner loop, V[j]*P[i][j] after.
  always_comb begin
    if (state == ST_VMUL) begin
      mul_a = vec_rdata;
      mul_b = p_acc;
    end else begin
      mul_a = left_rdata;
      mul_b = right_rdata;
    end
    prod_next = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Register every multiply before it is added.
      prod       <= prod_next;
      prod_valid <= rd_valid;
      // Issue one read pair per cycle of the inner loop.
      rd_valid   <= (state == ST_MAC);
      if (prod_valid) begin
        p_acc <= p_acc + prod;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_fire && cmd.op == OP_START) begin
            i       <= '0;
            j       <= '0;
            k       <= '0;
            p_acc   <= '0;
            row_acc <= '0;
            state   <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (k == DW'(DIM - 1)) begin
            state <= ST_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_DRAIN: begin
          // Hold until the last product has landed in p_acc.
          if (!rd_valid && !prod_valid) begin
            state <= ST_VMUL;
          end
        end
        ST_VMUL: begin
          state <= ST_VACC;
        end
        ST_VACC: begin
          if (j == DW'(DIM - 1)) begin
            out_valid <= 1'b1;
            out_index <= OUT_IDX_W'(i);
            out_value <= row_acc + prod;
            out_last  <= (i == RW'(ROWS - 1));
            state     <= ST_EMIT;
          end else begin
            row_acc <= row_acc + prod;
            j       <= j + 1'b1;
            k       <= '0;
            p_acc   <= '0;
            state   <= ST_MAC;
          end
        end
        ST_EMIT: begin
          if (res_fire) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= ST_IDLE;
            end else begin
              i       <= i + 1'b1;
              j       <= '0;
              k       <= '0;
              p_acc   <= '0;
              row_acc <= '0;
              state   <= ST_MAC;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A pending result never coexists with an open request port.
  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !res.valid)
    else $error("request port open while a result is pending");

  // A start closes the request port on the next cycle.
  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.op == OP_START) |=> !cmd.ready)
    else $error("request port still open after start");

  // Taking the last row returns the block to idle.
  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.last) |=> cmd.ready)
    else $error("block not idle after last result");

  // The vector multiply must see a fully drained inner loop.
  a_vmul_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VMUL) |-> (!rd_valid && !prod_valid))
    else $error("vector multiply started before inner loop drained");

  // Results appear only in the emit state.
  a_valid_in_emit: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == ST_EMIT))
    else $error("result valid outside emit state");
`endif

endmodule

// ===== sv/mmvp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmvp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks ((L * R) * V) row sums from matrix_matrix_vector_product_top against a
// behavioral copy of the block kept in the bench. Every store is loaded in full
// first, then directed requests, then a long random mix with stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb;
  import mmvp_pkg::*;

  localparam int DIM          = 8;
  localparam int ROWS         = 4;
  localparam int RUN_ITEMS    = 430;
  // A start request keeps the input closed until its last row sum is taken, and the
  // long receiver hold adds to that; the limit allows a wide margin over both.
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 600;
  localparam int TAIL_CYCLES  = 64;
  localparam int IDLE_PERCENT = 7;

  typedef struct {
    op_t                       op;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } mmvp_req_t;

  typedef struct {
    logic [OUT_IDX_W-1:0]      idx;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } row_sum_t;

  logic clk;
  logic rst;

  mmvp_cmd_if cmd_ch();
  mmvp_res_if res_ch();

  matrix_matrix_vector_product_top #(
    .DIM  (DIM),
    .ROWS (ROWS)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Requests waiting for the driver, and row sums still owed by the block.
  mmvp_req_t req_queue[$];
  row_sum_t  row_sums_due[$];

  // Bench copy of the block's stores.
  bit [VALUE_W-1:0] left_mat  [ROWS][DIM];
  bit [VALUE_W-1:0] right_mat [DIM][DIM];
  bit [VALUE_W-1:0] vec       [DIM];

  int   errors;
  int   pushed;
  int   req_count;
  int   sum_count;
  int   hold_left;
  logic hold_armed;
  logic hold_done;
  logic cmd_taken;

  // Quiet windows: no random idling on either side while these hold.
  wire calm_tx = (req_count >= 200) && (req_count < 290);
  wire calm_rx = (sum_count >= 40) && (sum_count < 90);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one accepted request to the bench stores; a start computes the
  // product L * R, then one dot product with V per row.
  task automatic predict_row_sums(input mmvp_req_t r);
    bit [VALUE_W-1:0] prod [ROWS][DIM];
    bit [VALUE_W-1:0] acc;
    row_sum_t         sum;
    case (r.op)
      OP_LOAD_LEFT: begin
        // Rows past ROWS are dropped by the block.
        if (r.row < ROWS) left_mat[r.row][r.col] = r.value;
      end
      OP_LOAD_RIGHT: begin
        right_mat[r.row][r.col] = r.value;
      end
      OP_LOAD_VECTOR: begin
        vec[r.col] = r.value;
      end
      OP_START: begin
        for (int i = 0; i < ROWS; i++) begin
          for (int j = 0; j < DIM; j++) begin
            prod[i][j] = '0;
            for (int k = 0; k < DIM; k++) begin
              prod[i][j] = prod[i][j] + left_mat[i][k] * right_mat[k][j];
            end
          end
        end
        for (int i = 0; i < ROWS; i++) begin
          acc = '0;
          for (int j = 0; j < DIM; j++) begin
            acc = acc + vec[j] * prod[i][j];
          end
          sum.idx   = OUT_IDX_W'(i);
          sum.value = acc;
          sum.last  = (i == ROWS - 1);
          row_sums_due.push_back(sum);
        end
      end
      default: ;
    endcase
  endtask

  function automatic void push_req(op_t op, int row, int col, logic [VALUE_W-1:0] value);
    mmvp_req_t r;
    r.op    = op;
    r.row   = IDX_W'(row);
    r.col   = IDX_W'(col);
    r.value = value;
    req_queue.push_back(r);
    pushed++;
  endfunction

  // Mostly full random words, with the signed extremes and small values mixed in.
  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Hold until the driver is empty and every owed row sum has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (req_queue.size() != 0 || cmd_ch.valid || row_sums_due.size() != 0);
  endtask

  // Request driver: change at the falling edge; advance only once the
  // current request was taken at the last rising edge.
  always @(negedge clk) begin
    mmvp_req_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (req_queue.size() != 0 && (calm_tx || $urandom_range(99) >= IDLE_PERCENT)) begin
        nxt = req_queue.pop_front();
        cmd_ch.op    <= nxt.op;
        cmd_ch.row   <= nxt.row;
        cmd_ch.col   <= nxt.col;
        cmd_ch.value <= nxt.value;
        cmd_ch.valid <= 1'b1;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Request monitor: feed every accepted request to the predictor.
  always @(posedge clk) begin
    mmvp_req_t seen;
    cmd_taken <= !rst && cmd_ch.valid && cmd_ch.ready;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      seen.op    = cmd_ch.op;
      seen.row   = cmd_ch.row;
      seen.col   = cmd_ch.col;
      seen.value = cmd_ch.value;
      predict_row_sums(seen);
      req_count++;
    end
  end

  // Result receiver: random ready, plus one long hold once armed so the
  // block backs up and closes its input while requests keep being offered.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_armed && !hold_done && res_ch.valid) begin
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm_rx || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Result monitor: compare each accepted row sum with the oldest one owed.
  always @(posedge clk) begin
    row_sum_t due;
    if (!rst && res_ch.valid && res_ch.ready) begin
      sum_count++;
      if (row_sums_due.size() == 0) begin
        $error("row sum with none owed: out_index %0d out_value %0d last %0b",
               res_ch.out_index, res_ch.out_value, res_ch.last);
        errors++;
      end else begin
        due = row_sums_due.pop_front();
        if (res_ch.out_index !== due.idx) begin
          $error("out_index: expected %0d, actual %0d", due.idx, res_ch.out_index);
          errors++;
        end
        if (res_ch.out_value !== due.value) begin
          $error("out_value: expected %0d, actual %0d", due.value, res_ch.out_value);
          errors++;
        end
        if (res_ch.last !== due.last) begin
          $error("last: expected %0b, actual %0b", due.last, res_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no handshake happens on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("matrix_matrix_vector_product_top verification failed");
    $finish;
  end

  initial begin : stimulus
    int pick;
    errors       = 0;
    pushed       = 0;
    req_count    = 0;
    sum_count    = 0;
    hold_left    = 0;
    hold_armed   = 1'b0;
    hold_done    = 1'b0;
    cmd_taken    = 1'b0;
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.op    = OP_LOAD_LEFT;
    cmd_ch.row   = '0;
    cmd_ch.col   = '0;
    cmd_ch.value = '0;
    res_ch.ready = 1'b0;

    // Load every store entry before any start: the stores come up unknown.
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < DIM; c++) push_req(OP_LOAD_LEFT, r, c, rand_word());
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c < DIM; c++) push_req(OP_LOAD_RIGHT, r, c, rand_word());
    for (int c = 0; c < DIM; c++) push_req(OP_LOAD_VECTOR, $urandom_range(7), c, rand_word());

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes in the corner entries, dropped left loads, ignored
    // fields on vector loads and starts, and back-to-back starts.
    push_req(OP_START, 0, 0, 0);
    push_req(OP_LOAD_LEFT, 0, 0, 32'h8000_0000);
    push_req(OP_LOAD_LEFT, ROWS - 1, DIM - 1, 32'h7FFF_FFFF);
    push_req(OP_LOAD_RIGHT, 0, 0, 32'h7FFF_FFFF);
    push_req(OP_LOAD_RIGHT, DIM - 1, DIM - 1, 32'hFFFF_FFFF);
    push_req(OP_LOAD_VECTOR, 5, 0, 32'hFFFF_FFFF);
    push_req(OP_LOAD_VECTOR, 0, DIM - 1, 32'h8000_0000);
    push_req(OP_LOAD_LEFT, ROWS, 2, 32'h1234_5678);
    push_req(OP_LOAD_LEFT, 7, 7, 32'h8000_0000);
    push_req(OP_START, 7, 7, 32'h7FFF_FFFF);
    push_req(OP_START, 2, 5, 32'hFFFF_FFFF);
    push_req(OP_LOAD_RIGHT, 3, 5, 32'h0000_0000);
    push_req(OP_LOAD_VECTOR, 2, 3, 32'h0000_0001);
    push_req(OP_START, 0, 0, 0);

    // Pause the sender until the block has answered everything.
    wait_drained();

    // Random mix; the first start triggers the long receiver hold.
    hold_armed = 1'b1;
    push_req(OP_START, $urandom_range(7), $urandom_range(7), $urandom);
    while (pushed < RUN_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 28)
        push_req(OP_LOAD_LEFT, $urandom_range(ROWS - 1), $urandom_range(7), rand_word());
      else if (pick < 56)
        push_req(OP_LOAD_RIGHT, $urandom_range(7), $urandom_range(7), rand_word());
      else if (pick < 70)
        push_req(OP_LOAD_VECTOR, $urandom_range(7), $urandom_range(7), rand_word());
      else if (pick < 84)
        push_req(OP_LOAD_LEFT, $urandom_range(7, ROWS), $urandom_range(7), rand_word());
      else
        push_req(OP_START, $urandom_range(7), $urandom_range(7), $urandom);
    end

    wait_drained();
    // Let any stray row sum show up before judging.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("matrix_matrix_vector_product_top verification clean");
    end else begin
      $display("matrix_matrix_vector_product_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mmvp_pkg.sv
sv/mmvp_if.sv
sv/mmvp_ram.sv
sv/matrix_matrix_vector_product_top.sv
tb/tb.sv
